// ===== rtl/ascii_axis_step_pulser_assert.svh =====
// Assertion macros used by the step pulser controller RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASCII_AXIS_STEP_PULSER_ASSERT_SVH
`define ASCII_AXIS_STEP_PULSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ASP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/asp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package asp_pkg;

    // Command characters.
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_T_LO  = 8'h74;
    localparam logic [7:0] CHAR_T_UP  = 8'h54;
    localparam logic [7:0] CHAR_P_LO  = 8'h70;
    localparam logic [7:0] CHAR_P_UP  = 8'h50;
    localparam logic [7:0] CHAR_S_LO  = 8'h73;
    localparam logic [7:0] CHAR_S_UP  = 8'h53;

    // Item kind carried on the cmd field.
    localparam logic ITEM_BYTE = 1'b0;
    localparam logic ITEM_TICK = 1'b1;

    // Controller modes, one-hot.
    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_COLLECT = 4'b0010,
        MODE_HIGH    = 4'b0100,
        MODE_LOW     = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        AXIS_SLIDE = 2'd0,
        AXIS_PAN   = 2'd1,
        AXIS_TILT  = 2'd2
    } axis_t;

    typedef struct packed {
        logic  is_axis;
        axis_t axis;
    } cmd_decode_t;

    // Everything in one result except the pulse count.
    typedef struct packed {
        logic       slide_step;
        logic       pan_step;
        logic       tilt_step;
        logic       count_valid;
        logic       bad_command;
        logic [7:0] bad_char;
    } asp_result_t;

    // Classifies a byte handled as a command.
    function automatic cmd_decode_t decode_cmd(input logic [7:0] b);
        cmd_decode_t d;
        d.is_axis = 1'b1;
        d.axis    = AXIS_SLIDE;
        if (b == CHAR_T_LO || b == CHAR_T_UP) begin
            d.axis = AXIS_TILT;
        end else if (b == CHAR_P_LO || b == CHAR_P_UP) begin
            d.axis = AXIS_PAN;
        end else if (b == CHAR_S_LO || b == CHAR_S_UP) begin
            d.axis = AXIS_SLIDE;
        end else begin
            d.is_axis = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/asp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "ascii_axis_step_pulser_assert.svh"

module asp_ctrl
    import asp_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic                  item_cmd,
    input  wire logic [7:0]            item_byte,
    output asp_result_t                res,
    output logic      [COUNT_BITS-1:0] res_count
);

    mode_t                 mode_reg,         mode_next;
    axis_t                 axis_reg,         axis_next;
    logic [VALUE_BITS-1:0] half_period_reg,  half_period_next;
    logic [VALUE_BITS-1:0] tick_counter_reg, tick_counter_next;
    logic [COUNT_BITS-1:0] period_count_reg, period_count_next;
    logic                  stop_pending_reg, stop_pending_next;
    logic [7:0]            held_byte_reg,    held_byte_next;

    cmd_decode_t           rx_dec;
    cmd_decode_t           held_dec;
    logic [VALUE_BITS:0]   tick_inc;
    logic                  half_done;
    logic [VALUE_BITS-1:0] value_acc;
    logic [COUNT_BITS-1:0] period_inc;
    logic                  level;

    assign rx_dec     = decode_cmd(item_byte);
    assign held_dec   = decode_cmd(held_byte_reg);
    assign tick_inc   = {1'b0, tick_counter_reg} + {{VALUE_BITS{1'b0}}, 1'b1};
    assign half_done  = tick_inc >= {1'b0, half_period_reg};
    assign period_inc = period_count_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    // Decimal accumulate: value * 10 + byte - '0', wrapping.
    assign value_acc  = (half_period_reg << 3) + (half_period_reg << 1)
                      + VALUE_BITS'(item_byte) - VALUE_BITS'(CHAR_ZERO);

    // Next state and result for the item in the input register.
    always_comb
    begin
        mode_next         = mode_reg;
        axis_next         = axis_reg;
        half_period_next  = half_period_reg;
        tick_counter_next = tick_counter_reg;
        period_count_next = period_count_reg;
        stop_pending_next = stop_pending_reg;
        held_byte_next    = held_byte_reg;
        res               = '0;
        res_count         = '0;

        case (mode_reg)
            MODE_IDLE:
            begin
                if (item_cmd == ITEM_BYTE) begin
                    if (rx_dec.is_axis) begin
                        axis_next        = rx_dec.axis;
                        mode_next        = MODE_COLLECT;
                        half_period_next = '0;
                    end else begin
                        res.bad_command = 1'b1;
                        res.bad_char    = item_byte;
                    end
                end
            end
            MODE_COLLECT:
            begin
                if (item_cmd == ITEM_BYTE) begin
                    if (item_byte == CHAR_SLASH) begin
                        mode_next         = MODE_HIGH;
                        tick_counter_next = '0;
                        period_count_next = '0;
                        stop_pending_next = 1'b0;
                    end else if (item_byte != 8'd0) begin
                        half_period_next = value_acc;
                    end
                end
            end
            MODE_HIGH, MODE_LOW:
            begin
                if (item_cmd == ITEM_BYTE) begin
                    // Only the first byte of a run is kept.
                    if (!stop_pending_reg) begin
                        stop_pending_next = 1'b1;
                        held_byte_next    = item_byte;
                    end
                end else if (half_done) begin
                    tick_counter_next = '0;
                    if (mode_reg == MODE_HIGH) begin
                        mode_next = MODE_LOW;
                    end else begin
                        period_count_next = period_inc;
                        if (stop_pending_reg) begin
                            // Run ends: report and replay the held byte as a command.
                            res.count_valid   = 1'b1;
                            res_count         = period_inc;
                            stop_pending_next = 1'b0;
                            mode_next         = MODE_IDLE;
                            if (held_dec.is_axis) begin
                                axis_next        = held_dec.axis;
                                mode_next        = MODE_COLLECT;
                                half_period_next = '0;
                            end else begin
                                res.bad_command = 1'b1;
                                res.bad_char    = held_byte_reg;
                            end
                        end else begin
                            mode_next = MODE_HIGH;
                        end
                    end
                end else begin
                    tick_counter_next = tick_inc[VALUE_BITS-1:0];
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // Step pin levels after this item.
        level = (mode_next == MODE_HIGH);
        case (axis_next)
            AXIS_SLIDE: res.slide_step = level;
            AXIS_PAN:   res.pan_step   = level;
            AXIS_TILT:  res.tilt_step  = level;
            default:    res.slide_step = 1'b0;
        endcase
    end

    // State registers advance once per processed transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg         <= MODE_IDLE;
            axis_reg         <= AXIS_SLIDE;
            half_period_reg  <= '0;
            tick_counter_reg <= '0;
            period_count_reg <= '0;
            stop_pending_reg <= 1'b0;
            held_byte_reg    <= '0;
        end else if (step) begin
            mode_reg         <= mode_next;
            axis_reg         <= axis_next;
            half_period_reg  <= half_period_next;
            tick_counter_reg <= tick_counter_next;
            period_count_reg <= period_count_next;
            stop_pending_reg <= stop_pending_next;
            held_byte_reg    <= held_byte_next;
        end
    end

    // At most one axis pin is ever driven.
    `ASP_ASSERT_IMP(a_one_pin, step, $onehot0({res.slide_step, res.pan_step, res.tilt_step}), "more than one step pin high")
    // A count is reported only at the end of a low half, on a tick.
    `ASP_ASSERT_IMP(a_count_src, step && res.count_valid, mode_reg == MODE_LOW && item_cmd == ITEM_TICK, "count reported outside a low half")
    // Ticks leave an idle controller idle.
    `ASP_ASSERT_NXT(a_idle_tick, step && mode_reg == MODE_IDLE && item_cmd == ITEM_TICK, mode_reg == MODE_IDLE, "tick changed idle mode")
    // Once a byte is held, later bytes do not replace it.
    `ASP_ASSERT_NXT(a_held_keep, step && stop_pending_reg && item_cmd == ITEM_BYTE && (mode_reg == MODE_HIGH || mode_reg == MODE_LOW), $stable(held_byte_reg), "held byte overwritten")

endmodule

`default_nettype wire

// ===== rtl/ascii_axis_step_pulser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Three-axis step pulse generator driven by ASCII commands.
// Input channel (in_valid/in_ready): one transaction is either a received byte
// (cmd = 0, rx_byte) or a one millisecond tick (cmd = 1).
// Output channel (out_valid/out_ready): exactly one transaction per input
// transaction, in order, carrying the three step pin levels, a pulse count
// report flag with the count, and a bad command flag with the rejected byte.
// The input register feeds the command logic, which writes the result register
// when it is empty or being drained; out_valid rises as that register loads.
// Throughput is one transaction per cycle while the receiver does not stall;
// the decimal accumulate (value * 10) and the tick compare are the longest
// paths between the two registers.
// Reset clears the control state: idle, slide axis selected, both channels
// empty. The result register, and so the step pins, is not reset.
// When the receiver stalls, the result register holds and the input register
// keeps one more transaction; in_ready then drops until the output moves.

module ascii_axis_step_pulser
    import asp_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  cmd,
    input  wire logic [7:0]            rx_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       slide_step,
    output logic                       pan_step,
    output logic                       tilt_step,
    output logic                       count_valid,
    output logic      [COUNT_BITS-1:0] pulse_count,
    output logic                       bad_command,
    output logic      [7:0]            bad_char
);

    logic                  in_valid_reg;
    logic                  cmd_reg;
    logic [7:0]            byte_reg;
    logic                  out_valid_reg;
    asp_result_t           result_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic                  out_load;
    logic                  step;
    asp_result_t           result_next;
    logic [COUNT_BITS-1:0] count_next;

    // Handshake: the result register loads when empty or being drained.
    assign out_load = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && out_load;
    assign in_ready = !in_valid_reg || out_load;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            cmd_reg  <= cmd;
            byte_reg <= rx_byte;
        end
    end

    asp_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item_cmd  (cmd_reg),
        .item_byte (byte_reg),
        .res       (result_next),
        .res_count (count_next)
    );

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (step) begin
            result_reg <= result_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign slide_step  = result_reg.slide_step;
    assign pan_step    = result_reg.pan_step;
    assign tilt_step   = result_reg.tilt_step;
    assign count_valid = result_reg.count_valid;
    assign pulse_count = count_reg;
    assign bad_command = result_reg.bad_command;
    assign bad_char    = result_reg.bad_char;

endmodule

`default_nettype wire
